// ===== rtl/mseq_pkg.sv =====
`default_nettype none

package mseq_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CODE_W      = 16;
    localparam int unsigned SEED_W      = 32;
    localparam int unsigned RATIO_W     = 16;
    localparam int unsigned HOLD_W      = RATIO_W + 1;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned RES_W       = 5;

    // feedback tap position of the shift register
    localparam int unsigned TAP_BIT = 12;

    localparam logic [SEED_W-1:0]  SEED_RESET       = 32'h0000_0001;
    localparam logic [RES_W-1:0]   RES_RESET        = 5'd16;
    localparam logic [RES_W-1:0]   RES_MIN          = 5'd8;
    localparam logic [RES_W-1:0]   RES_MAX          = 5'd16;
    localparam logic [HOLD_W-1:0]  HOLD_RESET       = 17'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_HIGH  = 3'd0,
        REG_LEVEL_LOW   = 3'd1,
        REG_SEED        = 3'd2,
        REG_HOLD_RATIO  = 3'd3,
        REG_START_DELAY = 3'd4,
        REG_RESOLUTION  = 3'd5,
        REG_OFFSET_BIN  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic restart;
    } tick_t;

    typedef struct packed {
        logic [CODE_W-1:0] sample;
        logic              seq_bit;
        logic              delaying;
    } code_t;

    // control from the top level to the sequence core
    typedef struct packed {
        logic seed_load;
        logic advance;
        logic restart;
    } lfsr_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mseq_chan_if.sv =====
`default_nettype none

interface mseq_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/msequence_stimulus_generator.sv =====
`default_nettype none

// M-sequence stimulus generator.
// Channels: tick (sink) takes one word per converter sample tick, carrying
// the restart flag; code (source) gives one word per tick with the
// converter sample, the current sequence bit and the delaying flag.
// Configuration: cfg_we / cfg_index / cfg_wdata write one register per
// clock; writing seed also loads the shift register, writing start_delay
// also reloads the delay countdown. The user must let writes go in only
// while the block is idle; the block itself does not enforce it. Each tick
// word accepted goes to the code output register, one word per clock
// unless code stalls; the state update, the level select and the offset
// binary conversion all sit between the state registers and that register.
// Stall: the output register holds its word while code.ready is low; tick
// is still taken in that cycle only if the held word leaves at the same
// edge, so nothing is dropped or duplicated.
// Reset: registers return to their reset values (seed 1, resolution 16,
// the rest 0), the sequence bit to 1, the hold counter to 1, no delay, and
// the output register empties.
module msequence_stimulus_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mseq_chan_if.sink                                tick,
    mseq_chan_if.source                              code,
    input  wire logic                                cfg_we,
    input  wire logic [mseq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mseq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration registers
    logic [mseq_pkg::CODE_W-1:0]  level_high_reg;
    logic [mseq_pkg::CODE_W-1:0]  level_low_reg;
    logic [mseq_pkg::SEED_W-1:0]  seed_reg;
    logic [mseq_pkg::RATIO_W-1:0] hold_ratio_reg;
    logic [mseq_pkg::RES_W-1:0]   resolution_reg;
    logic                         offset_bin_reg;

    logic [mseq_pkg::DELAY_W-1:0] delay_left_reg;

    // output register
    logic                         out_valid_reg;
    mseq_pkg::code_t              out_word_reg, out_word_next;

    logic                         accept;
    logic                         delay_active;
    logic                         seed_wr;
    logic                         delay_wr;
    logic                         bit_next;
    logic [mseq_pkg::SEED_W-1:0]  lfsr_seed;
    mseq_pkg::lfsr_ctrl_t         lfsr_ctrl;

    logic [mseq_pkg::RES_W-1:0]   res_eff;
    logic [mseq_pkg::RES_W-1:0]   res_shift;
    logic [mseq_pkg::CODE_W-1:0]  level;
    logic [mseq_pkg::CODE_W-1:0]  msb_mask;
    logic [mseq_pkg::CODE_W-1:0]  full_mask;

    assign tick.ready   = !out_valid_reg || code.ready;
    assign accept       = tick.valid && tick.ready;
    assign delay_active = (delay_left_reg != '0);

    assign seed_wr  = cfg_we && (mseq_pkg::cfg_idx_t'(cfg_index) == mseq_pkg::REG_SEED);
    assign delay_wr = cfg_we && (mseq_pkg::cfg_idx_t'(cfg_index) == mseq_pkg::REG_START_DELAY);

    // a seed write loads the shift register with the new value at the same
    // edge as the seed register itself
    assign lfsr_seed = seed_wr ? cfg_wdata[mseq_pkg::SEED_W-1:0] : seed_reg;

    assign lfsr_ctrl.seed_load = seed_wr;
    assign lfsr_ctrl.advance   = accept && !delay_active;
    assign lfsr_ctrl.restart   = tick.data.restart;

    mseq_lfsr u_lfsr (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (lfsr_seed),
        .hold_ratio (hold_ratio_reg),
        .ctrl       (lfsr_ctrl),
        .bit_next   (bit_next)
    );

    // Offset binary masks: resolution clamped to 8..16, masks shifted down
    // from the 16-bit forms.
    always_comb
    begin
        if (resolution_reg < mseq_pkg::RES_MIN)
        begin
            res_eff = mseq_pkg::RES_MIN;
        end
        else if (resolution_reg > mseq_pkg::RES_MAX)
        begin
            res_eff = mseq_pkg::RES_MAX;
        end
        else
        begin
            res_eff = resolution_reg;
        end
        res_shift = mseq_pkg::RES_MAX - res_eff;
        msb_mask  = {1'b1, {(mseq_pkg::CODE_W-1){1'b0}}} >> res_shift[3:0];
        full_mask = {mseq_pkg::CODE_W{1'b1}} >> res_shift[3:0];
    end

    // Result word for the tick being accepted.
    always_comb
    begin
        if (delay_active)
        begin
            level = '0;
        end
        else if (bit_next)
        begin
            level = level_high_reg;
        end
        else
        begin
            level = level_low_reg;
        end
        if (offset_bin_reg)
        begin
            out_word_next.sample = (level ^ msb_mask) & full_mask;
        end
        else
        begin
            out_word_next.sample = level;
        end
        out_word_next.seq_bit  = bit_next;
        out_word_next.delaying = delay_active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_high_reg <= '0;
            level_low_reg  <= '0;
            seed_reg       <= mseq_pkg::SEED_RESET;
            hold_ratio_reg <= '0;
            resolution_reg <= mseq_pkg::RES_RESET;
            offset_bin_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (mseq_pkg::cfg_idx_t'(cfg_index))
                mseq_pkg::REG_LEVEL_HIGH:  level_high_reg <= cfg_wdata[mseq_pkg::CODE_W-1:0];
                mseq_pkg::REG_LEVEL_LOW:   level_low_reg  <= cfg_wdata[mseq_pkg::CODE_W-1:0];
                mseq_pkg::REG_SEED:        seed_reg       <= cfg_wdata[mseq_pkg::SEED_W-1:0];
                mseq_pkg::REG_HOLD_RATIO:  hold_ratio_reg <= cfg_wdata[mseq_pkg::RATIO_W-1:0];
                mseq_pkg::REG_RESOLUTION:  resolution_reg <= cfg_wdata[mseq_pkg::RES_W-1:0];
                mseq_pkg::REG_OFFSET_BIN:  offset_bin_reg <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // start delay countdown; a write to start_delay reloads it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_left_reg <= '0;
        end
        else if (delay_wr)
        begin
            delay_left_reg <= cfg_wdata[mseq_pkg::DELAY_W-1:0];
        end
        else if (accept && delay_active)
        begin
            delay_left_reg <= delay_left_reg - mseq_pkg::DELAY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (code.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign code.valid = out_valid_reg;
    assign code.data  = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/mseq_lfsr.sv =====
`default_nettype none

// Shift register, spilled bit and hold counter of the sequence.
module mseq_lfsr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mseq_pkg::SEED_W-1:0]   seed,
    input  wire logic [mseq_pkg::RATIO_W-1:0]  hold_ratio,
    input  wire mseq_pkg::lfsr_ctrl_t          ctrl,
    output logic                               bit_next
);

    logic [mseq_pkg::SEED_W-1:0] shift_reg, shift_next;
    logic                        spill_reg, spill_next;
    logic                        bit_reg;
    logic [mseq_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [mseq_pkg::HOLD_W-1:0] hold_dec;
    logic [mseq_pkg::SEED_W-1:0] src_reg;
    logic                        src_spill;
    logic                        new_bit;

    always_comb
    begin
        hold_dec   = hold_reg - mseq_pkg::HOLD_W'(1);
        src_reg    = shift_reg;
        src_spill  = spill_reg;
        hold_next  = hold_dec;
        shift_next = shift_reg;
        spill_next = spill_reg;
        bit_next   = bit_reg;
        new_bit    = 1'b0;
        if (ctrl.advance && (hold_dec == '0))
        begin
            if (ctrl.restart)
            begin
                // reseed ahead of the step
                src_reg   = seed;
                src_spill = 1'b0;
                hold_next = mseq_pkg::HOLD_RESET;
            end
            else
            begin
                hold_next = {1'b0, hold_ratio} + mseq_pkg::HOLD_W'(1);
            end
            new_bit    = src_reg[mseq_pkg::TAP_BIT] ^ src_spill;
            spill_next = src_reg[mseq_pkg::SEED_W-1];
            shift_next = {src_reg[mseq_pkg::SEED_W-2:0], new_bit};
            bit_next   = new_bit;
        end
        else if (!ctrl.advance)
        begin
            hold_next = hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= mseq_pkg::SEED_RESET;
            spill_reg <= 1'b0;
            bit_reg   <= 1'b1;
            hold_reg  <= mseq_pkg::HOLD_RESET;
        end
        else if (ctrl.seed_load)
        begin
            shift_reg <= seed;
        end
        else
        begin
            shift_reg <= shift_next;
            spill_reg <= spill_next;
            bit_reg   <= bit_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mseq_checker.sv =====
`default_nettype none

module mseq_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire mseq_pkg::code_t out_word
);

    logic last_vld_reg;
    logic last_delay_reg;
    logic last_bit_reg;
    logic out_acc;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_vld_reg   <= 1'b0;
            last_delay_reg <= 1'b0;
            last_bit_reg   <= 1'b0;
        end
        else if (out_acc)
        begin
            last_vld_reg   <= 1'b1;
            last_delay_reg <= out_word.delaying;
            last_bit_reg   <= out_word.seq_bit;
        end
    end

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");

    // an accepted input word is on the output in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word did not reach the output");

    // the sequence is frozen across consecutive delay words
    a_delay_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && out_word.delaying && last_vld_reg && last_delay_reg
        |-> out_word.seq_bit == last_bit_reg)
        else $error("sequence bit moved during start delay");

endmodule

bind msequence_stimulus_generator mseq_checker u_mseq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (code.valid),
    .out_ready (code.ready),
    .out_word  (code.data)
);

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
    import mseq_pkg::*;

    // no handshake for this many cycles means the block has hung
    localparam int WATCHDOG_LIMIT = 2000;
    // receiver hold-off used to fill the block and stall the tick channel
    localparam int LONG_HOLD_OFF  = 300;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    mseq_chan_if #(.data_t(tick_t)) tick_ch ();
    mseq_chan_if #(.data_t(code_t)) code_ch ();

    msequence_stimulus_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .code      (code_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor copy of the registers and the sequence state, at reset values
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]  lvl_one      = '0;
    logic [CODE_W-1:0]  lvl_zero     = '0;
    logic [SEED_W-1:0]  seed_word    = SEED_RESET;
    logic [RATIO_W-1:0] hold_span    = '0;
    logic [RES_W-1:0]   res_cfg      = RES_RESET;
    logic               ofs_cfg      = 1'b0;

    logic [SEED_W-1:0]  sr_word      = SEED_RESET;
    logic               spill_q      = 1'b0;
    logic               bit_q        = 1'b1;
    logic [HOLD_W-1:0]  hold_left    = HOLD_RESET;
    logic [DELAY_W-1:0] delay_left   = '0;

    code_t pending_codes[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int errors       = 0;
    int ticks_sent   = 0;
    int words_checked = 0;
    int cfg_writes   = 0;
    int restarts_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one tick word in, the code word it should produce out.
    // The delay countdown freezes the sequence; afterwards the hold counter
    // decides when the shift register steps. A restart only takes effect
    // on the tick at which the hold counter runs out, and leaves the
    // counter at 1 so the very next tick steps again.
    // ------------------------------------------------------------------
    function automatic code_t next_code(input logic restart);
        code_t             w;
        logic [CODE_W-1:0] lvl;
        logic [RES_W-1:0]  res;
        logic [CODE_W-1:0] msb_mask;
        logic [CODE_W-1:0] full_mask;
        logic              fb;

        if (delay_left != '0)
        begin
            delay_left = delay_left - 1'b1;
            lvl        = '0;
            w.delaying = 1'b1;
        end
        else
        begin
            hold_left = hold_left - 1'b1;
            if (hold_left == '0)
            begin
                hold_left = {1'b0, hold_span} + 1'b1;
                if (restart)
                begin
                    sr_word   = seed_word;
                    bit_q     = 1'b1;
                    spill_q   = 1'b0;
                    hold_left = HOLD_RESET;
                end
                fb      = sr_word[TAP_BIT] ^ spill_q;
                spill_q = sr_word[SEED_W-1];
                sr_word = {sr_word[SEED_W-2:0], fb};
                bit_q   = fb;
            end
            lvl        = bit_q ? lvl_one : lvl_zero;
            w.delaying = 1'b0;
        end

        // offset binary: flip the sign bit at the effective resolution and
        // mask off everything above it; out-of-range resolutions are clamped
        if (ofs_cfg)
        begin
            res = (res_cfg < RES_MIN) ? RES_MIN : ((res_cfg > RES_MAX) ? RES_MAX : res_cfg);
            msb_mask  = CODE_W'(32'd1 << (res - 1'b1));
            full_mask = CODE_W'((32'd1 << res) - 1);
            lvl = (lvl ^ msb_mask) & full_mask;
        end

        w.sample  = lvl;
        w.seq_bit = bit_q;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: mirrors register writes, queues a prediction for every
    // accepted tick word and checks every accepted code word in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        code_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                cfg_writes++;
                case (cfg_idx_t'(cfg_index))
                    REG_LEVEL_HIGH:  lvl_one  = cfg_wdata[CODE_W-1:0];
                    REG_LEVEL_LOW:   lvl_zero = cfg_wdata[CODE_W-1:0];
                    REG_SEED:
                    begin
                        seed_word = cfg_wdata[SEED_W-1:0];
                        sr_word   = cfg_wdata[SEED_W-1:0];
                    end
                    REG_HOLD_RATIO:  hold_span = cfg_wdata[RATIO_W-1:0];
                    REG_START_DELAY: delay_left = cfg_wdata[DELAY_W-1:0];
                    REG_RESOLUTION:  res_cfg = cfg_wdata[RES_W-1:0];
                    REG_OFFSET_BIN:  ofs_cfg = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (code_ch.valid && code_ch.ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $error("code word 0x%h arrived with none expected", code_ch.data);
                    errors++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    words_checked++;
                    if (code_ch.data.sample !== want.sample)
                    begin
                        $error("sample: expected 0x%h, got 0x%h", want.sample,
                               code_ch.data.sample);
                        errors++;
                    end
                    if (code_ch.data.seq_bit !== want.seq_bit)
                    begin
                        $error("seq_bit: expected %b, got %b", want.seq_bit,
                               code_ch.data.seq_bit);
                        errors++;
                    end
                    if (code_ch.data.delaying !== want.delaying)
                    begin
                        $error("delaying: expected %b, got %b", want.delaying,
                               code_ch.data.delaying);
                        errors++;
                    end
                end
            end

            if (tick_ch.valid && tick_ch.ready)
                pending_codes.push_back(next_code(tick_ch.data.restart));
        end
    end

    // Receiver: random stalls, or a counted hold-off stretch when asked for
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            code_ch.ready <= 1'b0;
        end
        else
            code_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: counts cycles in which no word moves on either channel
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (!rst_n || (tick_ch.valid && tick_ch.ready) ||
                 (code_ch.valid && code_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offer one tick word; valid stays high afterwards so back-to-back words
    // need no toggle. It drops when an idle gap is rolled or drain_codes stops offering.
    task automatic send_tick(input logic restart);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= tick_t'(restart);
        ticks_sent++;
        if (restart)
            restarts_sent++;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    // Stop offering and wait until every predicted word has come out.
    // One word per tick, so an empty queue means the block is idle.
    task automatic drain_codes();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
    endtask

    // One register write; we drops again before returning so back-to-back calls
    // never assign it twice in one step
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // register defaults straight out of reset: levels zero, seed 1
    task automatic check_reset_sequence();
        repeat (3) send_tick(1'b0);
        drain_codes();
    endtask

    // full-scale levels of both signs, and a restart with hold ratio 0
    task automatic check_level_extremes();
        write_reg(REG_LEVEL_HIGH, 32'h0000_7FFF);
        write_reg(REG_LEVEL_LOW, 32'h0000_8000);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        drain_codes();
    endtask

    // offset binary at full and minimum resolution, plus clamped values
    task automatic check_offset_binary();
        write_reg(REG_OFFSET_BIN, 32'd1);
        send_tick(1'b0);
        drain_codes();
        write_reg(REG_RESOLUTION, 32'd0);
        send_tick(1'b0);
        drain_codes();
        write_reg(REG_RESOLUTION, 32'd31);
        send_tick(1'b0);
        drain_codes();
        write_reg(REG_RESOLUTION, 32'd8);
        send_tick(1'b1);
        drain_codes();
    endtask

    // zero code during delay (converted too), then the longest delay,
    // cut short by rewriting the register
    task automatic check_start_delay();
        write_reg(REG_START_DELAY, 32'd2);
        repeat (3) send_tick(1'b1);
        drain_codes();
        write_reg(REG_START_DELAY, 32'h0000_FFFF);
        repeat (2) send_tick(1'b0);
        drain_codes();
        write_reg(REG_START_DELAY, 32'd0);
    endtask

    // all-ones and all-zero seeds, loaded straight into the shift register
    task automatic check_seed_extremes();
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        repeat (2) send_tick(1'b0);
        drain_codes();
        write_reg(REG_SEED, 32'h0000_0000);
        send_tick(1'b1);
        drain_codes();
    endtask

    // random settings, extremes mixed in, every register rewritten
    task automatic program_random_setting();
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] lo;
        logic [SEED_W-1:0] sd;

        case ($urandom_range(3))
            0:       hi = 16'h7FFF;
            1:       hi = 16'h8000;
            default: hi = CODE_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       lo = 16'h8000;
            1:       lo = 16'h0000;
            default: lo = CODE_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       sd = 32'hFFFF_FFFF;
            1:       sd = 32'h0000_0001;
            default: sd = $urandom;
        endcase
        write_reg(REG_LEVEL_HIGH, {16'h0, hi});
        write_reg(REG_LEVEL_LOW, {16'h0, lo});
        write_reg(REG_SEED, sd);
        // short holds keep the sequence moving; now and then a longer one
        if ($urandom_range(4) == 0)
            write_reg(REG_HOLD_RATIO, $urandom_range(60));
        else
            write_reg(REG_HOLD_RATIO, $urandom_range(4));
        write_reg(REG_START_DELAY, $urandom_range(8));
        write_reg(REG_RESOLUTION, $urandom_range(31));
        write_reg(REG_OFFSET_BIN, $urandom_range(1));
    endtask

    task automatic check_random_settings();
        int tx_modes[4] = '{0, 55, 0, 7};
        int rx_modes[4] = '{0, 0, 55, 7};

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = tx_modes[ph];
            rx_stall_pct = rx_modes[ph];
            for (int s = 0; s < 3; s++)
            begin
                drain_codes();
                program_random_setting();
                repeat (40) send_tick($urandom_range(9) == 0);
            end
        end
        drain_codes();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    // receiver holds off for a long stretch while ticks keep coming: the
    // output register fills and tick.ready must drop until it drains
    task automatic check_backpressure();
        rx_hold_left = LONG_HOLD_OFF;
        repeat (40) send_tick($urandom_range(7) == 0);
        drain_codes();
    endtask

    // longest hold: the counter reloads to 65536 at its next expiry.
    // Left for last since the sequence would otherwise stay frozen long after.
    task automatic check_long_hold();
        write_reg(REG_HOLD_RATIO, 32'h0000_FFFF);
        repeat (8) send_tick($urandom_range(1));
        drain_codes();
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        code_ch.ready = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_sequence();
        check_level_extremes();
        check_offset_binary();
        check_start_delay();
        check_seed_extremes();
        check_random_settings();
        check_backpressure();
        check_long_hold();

        // one word per tick with a single register stage: any stray word shows up
        // before this final check
        repeat (4) @(posedge clk);
        if (pending_codes.size() != 0)
        begin
            $error("%0d expected code words never arrived", pending_codes.size());
            errors++;
        end

        $display("Covered %0d tick words (%0d with restart) and %0d code words checked,",
                 ticks_sent, restarts_sent, words_checked);
        $display("over %0d register writes, four idling mixes and one long receiver hold-off.",
                 cfg_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
